### hw/rtl/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Types and fixed-point constants of the loose photon id cuts: eta bin
// bounds, effective areas per bin and the barrel and endcap cut sets.
// All constants but PT_MIN carry 24 fraction bits.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int N_TABLE = 16;
    localparam int BIN_W   = 4;
    localparam int EA_W    = 22;
    localparam int N_ISO   = 3;
    localparam int N_REG   = 2;

    // isolation slots
    localparam int ISO_CHG = 0;
    localparam int ISO_NEU = 1;
    localparam int ISO_PHO = 2;

    // region slots
    localparam int REG_BARREL = 0;
    localparam int REG_ENDCAP = 1;

    typedef logic [BIN_W-1:0] t_bin;
    typedef logic [EA_W-1:0]  t_ea;
    typedef logic [43:0]      t_bound;

    typedef struct packed {
        logic [20:0] hoe;
        logic [18:0] sie;
        logic [25:0] chg;
        logic [27:0] neu_c;
        logic [17:0] neu_a;
        logic [8:0]  neu_b;
        logic [26:0] pho_c;
        logic [16:0] pho_a;
    } t_cut_set;

    // pt > 20 GeV in 1/256 GeV
    localparam logic [19:0] PT_MIN = 20'd5120;

    localparam t_bound ETA_BOUND [N_TABLE] = '{
        44'd16777216, 44'd24813502, 44'd33554432, 44'd36909875,
        44'd38587597, 44'd40265318, 44'd16777199222784, 44'd16777199222784,
        44'd16777199222784, 44'd16777199222784, 44'd16777199222784,
        44'd16777199222784, 44'd16777199222784, 44'd16777199222784,
        44'd16777199222784, 44'd16777199222784
    };

    localparam t_ea EA_CHG [N_TABLE] = '{
        22'd645923, 22'd785174, 22'd729809, 22'd634179,
        22'd567070, 22'd526805, 22'd451307, 22'd451307,
        22'd451307, 22'd451307, 22'd451307, 22'd451307,
        22'd451307, 22'd451307, 22'd451307, 22'd451307
    };

    localparam t_ea EA_NEU [N_TABLE] = '{
        22'd1067031, 22'd1850527, 22'd1273391, 22'd395942,
        22'd253336, 22'd1174, 22'd221459, 22'd221459,
        22'd221459, 22'd221459, 22'd221459, 22'd221459,
        22'd221459, 22'd221459, 22'd221459, 22'd221459
    };

    localparam t_ea EA_PHO [N_TABLE] = '{
        22'd2080375, 22'd1833750, 22'd1058642, 22'd1306945,
        22'd1676044, 22'd1937768, 22'd2303512, 22'd2303512,
        22'd2303512, 22'd2303512, 22'd2303512, 22'd2303512,
        22'd2303512, 22'd2303512, 22'd2303512, 22'd2303512
    };

    localparam t_cut_set BARREL_CUTS = '{
        hoe:   21'd1761608,
        sie:   19'd172805,
        chg:   26'd47630516,
        neu_c: 28'd154149061,
        neu_a: 18'd211393,
        neu_b: 9'd436,
        pho_c: 27'd49593450,
        pho_a: 17'd58720
    };

    localparam t_cut_set ENDCAP_CUTS = '{
        hoe:   21'd486539,
        sie:   19'd463051,
        chg:   26'd36071014,
        neu_c: 28'd175674229,
        neu_a: 18'd199649,
        neu_b: 9'd419,
        pho_c: 27'd82124472,
        pho_a: 17'd67109
    };

    localparam t_cut_set CUT_SETS [N_REG] = '{BARREL_CUTS, ENDCAP_CUTS};

endpackage
`default_nettype wire

### hw/rtl/photon_loose_id_cuts_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// start passes the s1, s2, s3 valid registers to the result strobe register
// throughput: 1 request per cycle, set by the four-stage arithmetic pipeline
//   (bin search, isolation and limit multipliers, subtract/sum, compares)
// busy is always low; results cannot be held off and need no buffering
// reset: synchronous active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// photon_loose_id_cuts_unit
// Loose cut-based photon id with effective-area pileup correction of the
// charged, neutral and photon isolations, barrel and endcap cut sets ORed.
// ----------------------------------------------------------------------------
module photon_loose_id_cuts_unit
    import pli_pkg::*;
#(
    parameter int ETA_BINS = 7
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [14:0] i_abs_eta,
    input  wire logic [19:0] i_photon_pt,
    input  wire logic        i_in_barrel,
    input  wire logic        i_in_endcap,
    input  wire logic        i_electron_veto_ok,
    input  wire logic [17:0] i_hadronic_over_em,
    input  wire logic [15:0] i_sigma_ieta_ieta,
    input  wire logic [19:0] i_charged_iso,
    input  wire logic [19:0] i_neutral_iso,
    input  wire logic [19:0] i_photon_iso,
    input  wire logic [15:0] i_event_rho,
    output logic             o_result_valid,
    output logic             o_is_loose
);

    logic accept;

    // stage 1: bin and pt squared
    logic              r_s1_valid;
    t_bin              r_s1_bin,    n_s1_bin;
    logic [39:0]       r_s1_pt_sq,  n_s1_pt_sq;
    logic [19:0]       r_s1_pt;
    logic [N_REG-1:0]  r_s1_region;
    logic              r_s1_veto;
    logic [17:0]       r_s1_hoe;
    logic [15:0]       r_s1_sie;
    logic [19:0]       r_s1_iso [N_ISO];
    logic [15:0]       r_s1_rho;

    // stage 2: products
    logic              r_s2_valid;
    logic [N_REG-1:0]  r_s2_pre_ok,   n_s2_pre_ok;
    logic [19:0]       r_s2_iso      [N_ISO];
    logic [37:0]       r_s2_pu       [N_ISO];
    logic [37:0]       n_s2_pu       [N_ISO];
    logic [37:0]       r_s2_neu_lin  [N_REG];
    logic [37:0]       n_s2_neu_lin  [N_REG];
    logic [48:0]       r_s2_neu_quad [N_REG];
    logic [48:0]       n_s2_neu_quad [N_REG];
    logic [36:0]       r_s2_pho_lin  [N_REG];
    logic [36:0]       n_s2_pho_lin  [N_REG];

    // stage 3: corrected isolations and limits
    logic              r_s3_valid;
    logic [N_REG-1:0]  r_s3_pre_ok;
    logic [43:0]       r_s3_corr    [N_ISO];
    logic [43:0]       n_s3_corr    [N_ISO];
    logic [50:0]       r_s3_neu_lim [N_REG];
    logic [50:0]       n_s3_neu_lim [N_REG];
    logic [37:0]       r_s3_pho_lim [N_REG];
    logic [37:0]       n_s3_pho_lim [N_REG];

    // stage 4: result
    logic              r_result_valid;
    logic              r_is_loose, n_is_loose;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // first bin whose bound lies above eta, else the last bin
    always_comb begin
        n_s1_bin = BIN_W'(ETA_BINS - 1);
        for (int i = N_TABLE - 2; i >= 0; i--) begin
            if (i < ETA_BINS - 1 && {17'b0, i_abs_eta, 12'b0} < ETA_BOUND[i]) begin
                n_s1_bin = BIN_W'(i);
            end
        end
        n_s1_pt_sq = {20'b0, i_photon_pt} * {20'b0, i_photon_pt};
    end

    always_comb begin
        n_s2_pu[ISO_CHG] = {16'b0, EA_CHG[r_s1_bin]} * {22'b0, r_s1_rho};
        n_s2_pu[ISO_NEU] = {16'b0, EA_NEU[r_s1_bin]} * {22'b0, r_s1_rho};
        n_s2_pu[ISO_PHO] = {16'b0, EA_PHO[r_s1_bin]} * {22'b0, r_s1_rho};
        for (int r = 0; r < N_REG; r++) begin
            n_s2_neu_lin[r]  = {20'b0, CUT_SETS[r].neu_a} * {18'b0, r_s1_pt};
            n_s2_neu_quad[r] = {40'b0, CUT_SETS[r].neu_b} * {9'b0, r_s1_pt_sq};
            n_s2_pho_lin[r]  = {20'b0, CUT_SETS[r].pho_a} * {17'b0, r_s1_pt};
            n_s2_pre_ok[r]   = r_s1_region[r] && (r_s1_pt > PT_MIN) && r_s1_veto
                && ({r_s1_hoe, 8'b0} < {5'b0, CUT_SETS[r].hoe})
                && ({r_s1_sie, 8'b0} < {5'b0, CUT_SETS[r].sie});
        end
    end

    // isolation minus pileup, clamped at zero, and the neutral and photon limits
    always_comb begin
        for (int k = 0; k < N_ISO; k++) begin
            n_s3_corr[k] = ({r_s2_iso[k], 24'b0} > {6'b0, r_s2_pu[k]})
                ? {r_s2_iso[k], 24'b0} - {6'b0, r_s2_pu[k]} : '0;
        end
        for (int r = 0; r < N_REG; r++) begin
            n_s3_neu_lim[r] = {7'b0, CUT_SETS[r].neu_c, 16'b0}
                + {5'b0, r_s2_neu_lin[r], 8'b0} + {2'b0, r_s2_neu_quad[r]};
            n_s3_pho_lim[r] = {3'b0, CUT_SETS[r].pho_c, 8'b0} + {1'b0, r_s2_pho_lin[r]};
        end
    end

    always_comb begin
        n_is_loose = 1'b0;
        for (int r = 0; r < N_REG; r++) begin
            if (r_s3_pre_ok[r]
                && r_s3_corr[ISO_CHG] < {10'b0, CUT_SETS[r].chg, 8'b0}
                && {r_s3_corr[ISO_NEU], 8'b0} < {1'b0, r_s3_neu_lim[r]}
                && r_s3_corr[ISO_PHO] < {6'b0, r_s3_pho_lim[r]}) begin
                n_is_loose = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_s1_valid     <= accept;
            r_s2_valid     <= r_s1_valid;
            r_s3_valid     <= r_s2_valid;
            r_result_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bin                <= n_s1_bin;
        r_s1_pt_sq              <= n_s1_pt_sq;
        r_s1_pt                 <= i_photon_pt;
        r_s1_region[REG_BARREL] <= i_in_barrel;
        r_s1_region[REG_ENDCAP] <= i_in_endcap;
        r_s1_veto               <= i_electron_veto_ok;
        r_s1_hoe                <= i_hadronic_over_em;
        r_s1_sie                <= i_sigma_ieta_ieta;
        r_s1_iso[ISO_CHG]       <= i_charged_iso;
        r_s1_iso[ISO_NEU]       <= i_neutral_iso;
        r_s1_iso[ISO_PHO]       <= i_photon_iso;
        r_s1_rho                <= i_event_rho;

        r_s2_pre_ok   <= n_s2_pre_ok;
        r_s2_iso      <= r_s1_iso;
        r_s2_pu       <= n_s2_pu;
        r_s2_neu_lin  <= n_s2_neu_lin;
        r_s2_neu_quad <= n_s2_neu_quad;
        r_s2_pho_lin  <= n_s2_pho_lin;

        r_s3_pre_ok  <= r_s2_pre_ok;
        r_s3_corr    <= n_s3_corr;
        r_s3_neu_lim <= n_s3_neu_lim;
        r_s3_pho_lim <= n_s3_pho_lim;

        r_is_loose <= n_is_loose;
    end

    assign o_result_valid = r_result_valid;
    assign o_is_loose     = r_is_loose;

    // every request yields a result strobe
    a_request_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_result_valid)
        else $error("request did not produce a result strobe");

    // no result without a request
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, 4))
        else $error("result strobe without a request");

    // a loose photon needs a region, the veto and pt above threshold
    a_loose_needs_basics: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_is_loose) |->
            ($past(i_in_barrel || i_in_endcap, 4) && $past(i_electron_veto_ok, 4)
             && ($past(i_photon_pt, 4) > PT_MIN)))
        else $error("loose result without region, veto or pt");

endmodule
`default_nettype wire

### verif/photon_loose_id_cuts_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// photon loose id cuts testbench
// Streams photon candidates through the unit in random bursts and checks
// each loose flag against an exact integer prediction of the pileup-corrected
// barrel and endcap cuts. Most stimulus is shaped from the cut edges.
// ----------------------------------------------------------------------------
module testbench;

    typedef longint unsigned t_u64;

    typedef struct {
        bit [14:0] eta;
        bit [19:0] pt;
        bit        eb;
        bit        ee;
        bit        veto;
        bit [17:0] hoe;
        bit [15:0] sie;
        bit [19:0] chg;
        bit [19:0] neu;
        bit [19:0] pho;
        bit [15:0] rho;
        bit        wait_idle;
    } t_photon_cand;

    typedef struct {
        t_u64 hoe, sie, chg, neu_c, neu_a, neu_b, pho_c, pho_a;
    } t_cut_limits;

    typedef enum int {
        SPOIL_NONE, SPOIL_PT, SPOIL_VETO, SPOIL_HOE, SPOIL_SIE, SPOIL_CHG, SPOIL_NEU, SPOIL_PHO
    } t_spoil;

    localparam int   ETA_BIN_COUNT  = 7;
    localparam int   RANDOM_ITEMS   = 950;
    localparam int   CYCLE_LIMIT    = 200000;
    localparam int   MAX_REPORTS    = 100;
    localparam t_u64 PT_FLOOR       = 20 * 256;
    localparam t_u64 Q24_ONE        = 64'd16777216;

    // eta bin edges in 1/1000, area tables per bin (last entry repeats)
    localparam int EDGE_MILLI [16] = '{
        1000, 1479, 2000, 2200, 2300, 2400, 999999000, 999999000,
        999999000, 999999000, 999999000, 999999000, 999999000, 999999000,
        999999000, 999999000
    };
    localparam int CHG_AREA_E4 [7] = '{385, 468, 435, 378, 338, 314, 269};
    localparam int NEU_AREA_E5 [7] = '{6360, 11030, 7590, 2360, 1510, 7, 1320};
    localparam int PHO_AREA_E4 [7] = '{1240, 1093, 631, 779, 999, 1155, 1373};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [14:0] i_abs_eta = '0;
    logic [19:0] i_photon_pt = '0;
    logic        i_in_barrel = 1'b0;
    logic        i_in_endcap = 1'b0;
    logic        i_electron_veto_ok = 1'b0;
    logic [17:0] i_hadronic_over_em = '0;
    logic [15:0] i_sigma_ieta_ieta = '0;
    logic [19:0] i_charged_iso = '0;
    logic [19:0] i_neutral_iso = '0;
    logic [19:0] i_photon_iso = '0;
    logic [15:0] i_event_rho = '0;
    logic        o_result_valid;
    logic        o_is_loose;

    t_photon_cand pending[$];
    bit           loose_expected[$];
    int           burst_left = 0;
    int           gap_left = 0;
    int           cycle_count = 0;
    int           fail_count = 0;
    int           n_requests = 0;
    int           n_results = 0;
    int           n_loose = 0;
    int           n_both_flags = 0;
    int           n_no_flag = 0;

    photon_loose_id_cuts_unit #(
        .ETA_BINS(ETA_BIN_COUNT)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_abs_eta         (i_abs_eta),
        .i_photon_pt       (i_photon_pt),
        .i_in_barrel       (i_in_barrel),
        .i_in_endcap       (i_in_endcap),
        .i_electron_veto_ok(i_electron_veto_ok),
        .i_hadronic_over_em(i_hadronic_over_em),
        .i_sigma_ieta_ieta (i_sigma_ieta_ieta),
        .i_charged_iso     (i_charged_iso),
        .i_neutral_iso     (i_neutral_iso),
        .i_photon_iso      (i_photon_iso),
        .i_event_rho       (i_event_rho),
        .o_result_valid    (o_result_valid),
        .o_is_loose        (o_is_loose)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // fixed-point cut arithmetic
    // ------------------------------------------------------------------------
    // c = n/d with 24 fraction bits, halves rounded up
    function automatic t_u64 q24(t_u64 n, t_u64 d);
        return (n * 64'd33554432 + d) / (64'd2 * d);
    endfunction

    function automatic t_u64 eff_area(int iso, int bin);
        int k;
        k = (bin > 6) ? 6 : bin;
        case (iso)
            pli_pkg::ISO_CHG: return q24(t_u64'(CHG_AREA_E4[k]), 10000);
            pli_pkg::ISO_NEU: return q24(t_u64'(NEU_AREA_E5[k]), 100000);
            default:          return q24(t_u64'(PHO_AREA_E4[k]), 10000);
        endcase
    endfunction

    function automatic t_cut_limits cut_limits(int region);
        t_cut_limits l;
        if (region == pli_pkg::REG_ENDCAP) begin
            l = '{q24(29, 1000), q24(276, 10000), q24(2150, 1000), q24(10471, 1000),
                  q24(119, 10000), q24(25, 1000000), q24(4895, 1000), q24(40, 10000)};
        end else begin
            l = '{q24(105, 1000), q24(103, 10000), q24(2839, 1000), q24(9188, 1000),
                  q24(126, 10000), q24(26, 1000000), q24(2956, 1000), q24(35, 10000)};
        end
        return l;
    endfunction

    function automatic int eta_bin(bit [14:0] eta);
        int  bin;
        bit  found;
        bin = (ETA_BIN_COUNT - 1) & 15;
        found = 1'b0;
        for (int i = 0; i + 1 < ETA_BIN_COUNT && i < 16; i++) begin
            if (!found && (t_u64'(eta) << 12) < q24(t_u64'(EDGE_MILLI[i]), 1000)) begin
                bin = i;
                found = 1'b1;
            end
        end
        return bin;
    endfunction

    // smallest eta that falls in the bin above edge k
    function automatic int eta_edge(int k);
        return int'((q24(t_u64'(EDGE_MILLI[k]), 1000) + 4095) >> 12);
    endfunction

    // isolation minus rho*area, clamped at zero, in 2^-32 GeV
    function automatic t_u64 pileup_subtracted(bit [19:0] iso, bit [15:0] rho, t_u64 area);
        t_u64 a;
        t_u64 b;
        a = t_u64'(iso) << 24;
        b = t_u64'(rho) * area;
        return (a > b) ? a - b : 0;
    endfunction

    // neutral limit in 2^-40 GeV
    function automatic t_u64 neu_limit(t_cut_limits l, bit [19:0] pt);
        return (l.neu_c << 16) + ((l.neu_a * t_u64'(pt)) << 8)
             + l.neu_b * t_u64'(pt) * t_u64'(pt);
    endfunction

    // photon limit in 2^-32 GeV
    function automatic t_u64 pho_limit(t_cut_limits l, bit [19:0] pt);
        return (l.pho_c << 8) + l.pho_a * t_u64'(pt);
    endfunction

    function automatic bit region_ok(t_cut_limits l, t_photon_cand c,
                                     t_u64 chg, t_u64 neu, t_u64 pho);
        if (t_u64'(c.pt) <= PT_FLOOR || !c.veto) return 1'b0;
        if ((t_u64'(c.hoe) << 8) >= l.hoe) return 1'b0;
        if ((t_u64'(c.sie) << 8) >= l.sie) return 1'b0;
        if (chg >= (l.chg << 8)) return 1'b0;
        if ((neu << 8) >= neu_limit(l, c.pt)) return 1'b0;
        if (pho >= pho_limit(l, c.pt)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit loose_id(t_photon_cand c);
        int   bin;
        t_u64 chg;
        t_u64 neu;
        t_u64 pho;
        bin = eta_bin(c.eta);
        chg = pileup_subtracted(c.chg, c.rho, eff_area(pli_pkg::ISO_CHG, bin));
        neu = pileup_subtracted(c.neu, c.rho, eff_area(pli_pkg::ISO_NEU, bin));
        pho = pileup_subtracted(c.pho, c.rho, eff_area(pli_pkg::ISO_PHO, bin));
        return (c.eb && region_ok(cut_limits(pli_pkg::REG_BARREL), c, chg, neu, pho))
            || (c.ee && region_ok(cut_limits(pli_pkg::REG_ENDCAP), c, chg, neu, pho));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus shaping
    // ------------------------------------------------------------------------
    // smallest raw isolation whose corrected value reaches thr
    function automatic t_u64 raw_edge(t_u64 thr, bit [15:0] rho, t_u64 area);
        return (thr + t_u64'(rho) * area + Q24_ONE - 1) >> 24;
    endfunction

    function automatic t_u64 clip(t_u64 v, int bits);
        t_u64 top;
        top = (t_u64'(1) << bits) - 1;
        return (v > top) ? top : v;
    endfunction

    function automatic t_u64 below(t_u64 e);
        return (e == 0) ? 0 : t_u64'($urandom_range(0, 32'(clip(e - 1, 31))));
    endfunction

    function automatic t_u64 near_edge(t_u64 e);
        return (e == 0) ? t_u64'($urandom_range(0, 1))
                        : e - 1 + t_u64'($urandom_range(0, 2));
    endfunction

    function automatic t_photon_cand clean_candidate(int region);
        t_photon_cand c;
        c = '{default: '0};
        c.eta  = (region == pli_pkg::REG_ENDCAP) ? 15'd8192 : 15'd2000;
        c.pt   = 20'd10240;
        c.eb   = (region == pli_pkg::REG_BARREL);
        c.ee   = (region == pli_pkg::REG_ENDCAP);
        c.veto = 1'b1;
        c.sie  = 16'd400;
        return c;
    endfunction

    // well-formed candidate, mostly passing, sometimes pushed to or across one cut
    function automatic t_photon_cand shaped_candidate();
        t_photon_cand c;
        t_cut_limits  l;
        t_spoil       spoil;
        int           region;
        int           bin;
        t_u64         e_hoe, e_sie, e_chg, e_neu, e_pho;
        c = '{default: '0};
        region = $urandom_range(0, 1) ? pli_pkg::REG_ENDCAP : pli_pkg::REG_BARREL;
        l = cut_limits(region);
        case ($urandom_range(0, 3))
            0:       c.eta = 15'(eta_edge(int'($urandom_range(0, 5)))
                             + int'($urandom_range(0, 2)) - 1);
            1:       c.eta = 15'($urandom());
            default: c.eta = (region == pli_pkg::REG_BARREL) ? 15'($urandom_range(0, 6057))
                                                             : 15'($urandom_range(6414, 10240));
        endcase
        case ($urandom_range(0, 7))
            0:       c.pt = 20'(PT_FLOOR - 1 + t_u64'($urandom_range(0, 2)));
            1:       c.pt = 20'($urandom());
            default: c.pt = 20'($urandom_range(32'(PT_FLOOR + 1), 80000));
        endcase
        c.rho = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 10000));
        bin = eta_bin(c.eta);
        e_hoe = (l.hoe + 255) >> 8;
        e_sie = (l.sie + 255) >> 8;
        e_chg = raw_edge(l.chg << 8, c.rho, eff_area(pli_pkg::ISO_CHG, bin));
        e_neu = raw_edge((neu_limit(l, c.pt) + 255) >> 8, c.rho,
                         eff_area(pli_pkg::ISO_NEU, bin));
        e_pho = raw_edge(pho_limit(l, c.pt), c.rho, eff_area(pli_pkg::ISO_PHO, bin));
        c.hoe = 18'(clip(below(e_hoe), 18));
        c.sie = 16'(clip(below(e_sie), 16));
        c.chg = 20'(clip(below(e_chg), 20));
        c.neu = 20'(clip(below(e_neu), 20));
        c.pho = 20'(clip(below(e_pho), 20));
        spoil = $urandom_range(0, 1) ? SPOIL_NONE : t_spoil'($urandom_range(1, 7));
        case (spoil)
            SPOIL_PT:  c.pt  = 20'(PT_FLOOR - t_u64'($urandom_range(0, 1)));
            SPOIL_HOE: c.hoe = 18'(clip(near_edge(e_hoe), 18));
            SPOIL_SIE: c.sie = 16'(clip(near_edge(e_sie), 16));
            SPOIL_CHG: c.chg = 20'(clip(near_edge(e_chg), 20));
            SPOIL_NEU: c.neu = 20'(clip(near_edge(e_neu), 20));
            SPOIL_PHO: c.pho = 20'(clip(near_edge(e_pho), 20));
            default: ;
        endcase
        c.veto = (spoil != SPOIL_VETO);
        case ($urandom_range(0, 9))
            0: begin
                c.eb = 1'b0;
                c.ee = 1'b0;
            end
            1: begin
                c.eb = 1'b1;
                c.ee = 1'b1;
            end
            default: begin
                c.eb = (region == pli_pkg::REG_BARREL);
                c.ee = (region == pli_pkg::REG_ENDCAP);
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        t_photon_cand nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // request still waiting to be taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].wait_idle && (start || loose_expected.size() != 0))) begin
            nxt = pending.pop_front();
            i_abs_eta          <= nxt.eta;
            i_photon_pt        <= nxt.pt;
            i_in_barrel        <= nxt.eb;
            i_in_endcap        <= nxt.ee;
            i_electron_veto_ok <= nxt.veto;
            i_hadronic_over_em <= nxt.hoe;
            i_sigma_ieta_ieta  <= nxt.sie;
            i_charged_iso      <= nxt.chg;
            i_neutral_iso      <= nxt.neu;
            i_photon_iso       <= nxt.pho;
            i_event_rho        <= nxt.rho;
            start <= 1'b1;
            if (burst_left > 1) begin
                burst_left <= burst_left - 1;
            end else if ($urandom_range(0, 9) == 0) begin
                // long back-to-back stretch
                burst_left <= int'($urandom_range(100, 300));
                gap_left   <= 0;
            end else begin
                burst_left <= int'($urandom_range(1, 16));
                gap_left   <= int'($urandom_range(0, 8));
            end
        end else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_photon_cand seen;
        bit           want;
        if (i_rst_n) begin
            if (start && !busy) begin
                seen.eta       = i_abs_eta;
                seen.pt        = i_photon_pt;
                seen.eb        = i_in_barrel;
                seen.ee        = i_in_endcap;
                seen.veto      = i_electron_veto_ok;
                seen.hoe       = i_hadronic_over_em;
                seen.sie       = i_sigma_ieta_ieta;
                seen.chg       = i_charged_iso;
                seen.neu       = i_neutral_iso;
                seen.pho       = i_photon_iso;
                seen.rho       = i_event_rho;
                seen.wait_idle = 1'b0;
                loose_expected.push_back(loose_id(seen));
                n_requests++;
                if (seen.eb && seen.ee) n_both_flags++;
                if (!seen.eb && !seen.ee) n_no_flag++;
            end
            if (o_result_valid) begin
                if (loose_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result strobe with no request outstanding, got %0b",
                                 $time, o_is_loose);
                end else begin
                    want = loose_expected.pop_front();
                    if (want) n_loose++;
                    if (o_is_loose !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: is_loose mismatch on result %0d: expected %0b, got %0b",
                                     $time, n_results, want, o_is_loose);
                    end
                    n_results++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d requests queued, %0d results outstanding",
                     $time, pending.size(), loose_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_photon_cand c;
        t_u64         e;
        // extremes of every field
        c = '{default: '0};
        pending.push_back(c);
        c = '{default: '1};
        c.wait_idle = 1'b0;
        pending.push_back(c);
        // clean candidates in each region, both flags and no flag
        pending.push_back(clean_candidate(pli_pkg::REG_BARREL));
        pending.push_back(clean_candidate(pli_pkg::REG_ENDCAP));
        c = clean_candidate(pli_pkg::REG_BARREL);
        c.ee = 1'b1;
        pending.push_back(c);
        c.eb = 1'b0;
        c.ee = 1'b0;
        pending.push_back(c);
        // pt just at and above the floor, veto failed
        c = clean_candidate(pli_pkg::REG_BARREL);
        c.pt = 20'(PT_FLOOR);
        pending.push_back(c);
        c.pt = 20'(PT_FLOOR + 1);
        pending.push_back(c);
        c = clean_candidate(pli_pkg::REG_BARREL);
        c.veto = 1'b0;
        pending.push_back(c);
        // H/E edge in barrel, shower width edge in endcap
        c = clean_candidate(pli_pkg::REG_BARREL);
        e = (cut_limits(pli_pkg::REG_BARREL).hoe + 255) >> 8;
        c.hoe = 18'(e - 1);
        pending.push_back(c);
        c.hoe = 18'(e);
        pending.push_back(c);
        c = clean_candidate(pli_pkg::REG_ENDCAP);
        e = (cut_limits(pli_pkg::REG_ENDCAP).sie + 255) >> 8;
        c.sie = 16'(e - 1);
        pending.push_back(c);
        c.sie = 16'(e);
        pending.push_back(c);
        // each eta bin edge under maximum pileup, photon iso on the lower bin's edge
        for (int k = 0; k < 6; k++) begin
            c = clean_candidate(pli_pkg::REG_BARREL);
            c.ee  = 1'b1;
            c.rho = '1;
            c.pho = 20'(clip(raw_edge(pho_limit(cut_limits(pli_pkg::REG_BARREL), c.pt), c.rho,
                                      eff_area(pli_pkg::ISO_PHO, k)), 20));
            c.eta = 15'(eta_edge(k) - 1);
            pending.push_back(c);
            c.eta = 15'(eta_edge(k));
            pending.push_back(c);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                c.eta  = 15'($urandom());
                c.pt   = 20'($urandom());
                c.eb   = 1'($urandom());
                c.ee   = 1'($urandom());
                c.veto = 1'($urandom());
                c.hoe  = 18'($urandom());
                c.sie  = 16'($urandom());
                c.chg  = 20'($urandom());
                c.neu  = 20'($urandom());
                c.pho  = 20'($urandom());
                c.rho  = 16'($urandom());
            end else begin
                c = shaped_candidate();
            end
            // let the pipe drain completely a few times
            c.wait_idle = (n == 0 || n == 320 || n == 640);
            pending.push_back(c);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || start || loose_expected.size() != 0)
            @(posedge i_clk);
        // catch stray strobes after the last result
        repeat (10) @(posedge i_clk);

        $display("checked %0d candidates, %0d results, %0d flagged loose", n_requests,
                 n_results, n_loose);
        $display("%0d with both region flags, %0d with neither, %0d failures", n_both_flags,
                 n_no_flag, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/pli_pkg.sv
hw/rtl/photon_loose_id_cuts_unit.sv
verif/photon_loose_id_cuts_tb.sv
